FILE: rtl/mac_pkg.sv
// shared constants, codes and control structs of the metropolis acceptance block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package mac_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    // item modes
    localparam logic [1:0] MODE_STEP    = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 2'd3;

    localparam logic [31:0] START_TEMP_RST = 32'd65536;
    localparam logic [31:0] RUN_LENGTH_RST = 32'd1000000;

    // arithmetic
    localparam logic [31:0] EXP_NEG_ONE_Q32 = 32'd1580030169;
    localparam logic [3:0]  TAYLOR_TERMS    = 4'd14;
    localparam logic [15:0] MEAN_EMPTY      = 16'd32768;

    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = 65;
    localparam int DIV_W     = 64;
    localparam int DEN_W     = 34;
    localparam int DIV_CNT_W = 7;

    typedef struct packed {
        logic                 div_go;
        logic [DIV_CNT_W-1:0] div_cnt;
    } t_arith_cmd;

    typedef struct packed {
        logic clear;
        logic rd;
        logic wr;
    } t_win_cmd;

endpackage

FILE: rtl/mac_in_if.sv
// input item channel of the metropolis acceptance block
// valid/ready handshake with the step payload; no dependencies
`timescale 1ns / 1ps
interface mac_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] score_delta;
    logic [15:0]        random_fraction;
    logic signed [47:0] initial_score;

    modport source (output valid, mode, score_delta, random_fraction, initial_score,
                    input ready);
    modport sink   (input valid, mode, score_delta, random_fraction, initial_score,
                    output ready);
endinterface

FILE: rtl/mac_out_if.sv
// result item channel of the metropolis acceptance block
// valid/ready handshake with the decision payload; no dependencies
`timescale 1ns / 1ps
interface mac_out_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               worse_move;
    logic [15:0]        accept_probability;
    logic [15:0]        window_mean;
    logic [31:0]        current_temperature;
    logic signed [47:0] running_score;
    logic               run_done;

    modport source (output valid, accepted, worse_move, accept_probability, window_mean,
                    current_temperature, running_score, run_done, input ready);
    modport sink   (input valid, accepted, worse_move, accept_probability, window_mean,
                    current_temperature, running_score, run_done, output ready);
endinterface

FILE: rtl/mac_arith.sv
// shared arithmetic unit: registered 33x32 multiplier and a restoring divider
// that retires one quotient bit per cycle; depends on mac_pkg
`timescale 1ns / 1ps
module mac_arith (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [mac_pkg::MUL_A_W-1:0]          i_mul_a,
    input  logic [mac_pkg::MUL_B_W-1:0]          i_mul_b,
    input  mac_pkg::t_arith_cmd                  i_cmd,
    input  logic [mac_pkg::DIV_W-1:0]            i_div_num,
    input  logic [mac_pkg::DEN_W-1:0]            i_div_den,
    output logic [mac_pkg::PROD_W-1:0]           o_prod,
    output logic [mac_pkg::DIV_W-1:0]            o_quo,
    output logic                                 o_div_busy,
    output logic                                 o_div_done
);
    import mac_pkg::*;

    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    mul_full;
    logic [DIV_W-1:0]     r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DEN_W:0]       rem_sh;
    logic                 ge;

    assign mul_full = PROD_W'(i_mul_a) * PROD_W'(i_mul_b);
    // dividend is left aligned, so its msb enters the remainder first
    assign rem_sh   = {r_rem, r_q[DIV_W-1]};
    assign ge       = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full;
        if (i_cmd.div_go) begin
            r_q   <= i_div_num;
            r_rem <= '0;
            r_den <= i_div_den;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_go) begin
                r_cnt <= i_cmd.div_cnt;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod     = r_prod;
    assign o_quo      = r_q;
    assign o_div_busy = (r_cnt != '0);
    assign o_div_done = r_done;
endmodule

FILE: rtl/mac_window.sv
// circular window of recorded probabilities with running total and fill count
// depends on mac_pkg
`timescale 1ns / 1ps
module mac_window #(
    parameter int WINDOW_DEPTH = mac_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mac_pkg::t_win_cmd                     i_cmd,
    input  logic [15:0]                           i_prob,
    output logic [16+$clog2(WINDOW_DEPTH+1)-1:0]  o_total,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]     o_fill
);
    import mac_pkg::*;

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = 16 + FW;

    logic [15:0]   r_mem [WINDOW_DEPTH];
    logic [15:0]   r_old;
    logic [PW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    logic [TW-1:0] r_total;
    logic [PW-1:0] next_pos;
    logic          full;
    logic [TW-1:0] base;

    assign next_pos = (r_pos >= PW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
    assign full     = r_fill >= FW'(WINDOW_DEPTH);
    // oldest entry drops out once the window is full
    assign base     = !full ? r_total :
                      (r_total >= TW'(r_old)) ? r_total - TW'(r_old) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_old <= r_mem[next_pos];
        end
        if (i_cmd.wr) begin
            r_mem[next_pos] <= i_prob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else if (i_cmd.wr) begin
            r_pos   <= next_pos;
            r_fill  <= full ? FW'(WINDOW_DEPTH) : r_fill + 1'b1;
            r_total <= base + TW'(i_prob);
        end
    end

    assign o_total = r_total;
    assign o_fill  = r_fill;
endmodule

FILE: rtl/metropolis_accept_with_cooling.sv
// top level of the metropolis acceptance block: sequencer, state and config
// depends on mac_pkg, mac_in_if, mac_out_if, mac_arith, mac_window
//
// usage: items enter on i_in (valid/ready) and one result item per input item
// leaves on o_out (valid/ready). mode 0 evaluates a move, mode 1 clears the
// probability window, mode 2 restarts the schedule and loads the score.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle; the block itself does not enforce this.
// one item at a time: i_in.ready is high only while idle. the work per item is set
// by the shared divider, which retires one quotient bit per cycle, and by the 14-term
// series of the exponential, each term a multiply and a divide on that same unit.
// the temperature costs one exponential, a worse move at nonzero temperature another.
// the result is held in output registers until o_out.ready; a stalled receiver
// just holds the block in its output state.
// reset (synchronous, active low) restores the register defaults, zeroes the
// iteration count, score and window bookkeeping; the window memory is not cleared.
`timescale 1ns / 1ps
module metropolis_accept_with_cooling #(
    parameter int WINDOW_DEPTH = mac_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mac_in_if.sink                           i_in,
    mac_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [mac_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mac_pkg::*;

    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = 16 + FW;

    typedef enum logic [4:0] {
        S_IDLE, S_T_MUL, S_T_DIV, S_T_WAIT, S_EXP_START, S_TAY_MUL, S_TAY_DIV,
        S_TAY_WAIT, S_REC_DIV, S_REC_WAIT, S_EXP_NEG, S_EXP_ACC, S_EXP_DONE,
        S_T_ROUND, S_STEP_EVAL, S_P_WAIT, S_WIN_RD, S_WIN_WR, S_SCORE,
        S_MEAN_GO, S_MEAN_WAIT, S_OUT
    } t_state;

    t_state             r_state;

    // configuration
    logic               r_maximize;
    logic [31:0]        r_start_temp;
    logic [23:0]        r_decay;
    logic [31:0]        r_run_length;

    // kept state
    logic [31:0]        r_count;
    logic signed [47:0] r_score;

    // item and working registers
    logic [1:0]         r_mode;
    logic signed [31:0] r_delta;
    logic [15:0]        r_rnd;
    logic [63:0]        r_x;
    logic [4:0]         r_n;
    logic [31:0]        r_f;
    logic [32:0]        r_term;
    logic [33:0]        r_sum;
    logic [3:0]         r_k;
    logic [32:0]        r_y;
    logic               r_ret_prob;

    // result registers
    logic               r_acc;
    logic               r_worse;
    logic [15:0]        r_prob;
    logic [15:0]        r_mean;
    logic [31:0]        r_temp;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    t_arith_cmd         arith_cmd;
    logic [DIV_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [PROD_W-1:0]  prod;
    logic [DIV_W-1:0]   quo;
    logic               div_busy;
    logic               div_done;

    t_win_cmd           win_cmd;
    logic [TW-1:0]      win_total;
    logic [FW-1:0]      win_fill;

    logic [31:0]        eff_len;
    logic [31:0]        it_clamped;
    logic [31:0]        mag;
    logic               is_worse;
    logic [PROD_W-1:0]  prod_rnd;
    logic [33:0]        p_rnd;
    logic [48:0]        score_sum;

    assign eff_len    = (r_run_length == '0) ? 32'd1 : r_run_length;
    assign it_clamped = (r_count < eff_len) ? r_count : eff_len;
    assign mag        = r_delta[31] ? 32'(-r_delta) : r_delta;
    assign is_worse   = r_maximize ? r_delta[31] : (!r_delta[31] && r_delta != '0);
    assign prod_rnd   = prod + {33'd0, 1'b1, 31'd0};
    assign p_rnd      = {1'b0, r_y} + 34'd32768;
    assign score_sum  = {r_score[47], r_score} + 49'(r_delta);

    mac_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mul_a    (mul_a),
        .i_mul_b    (mul_b),
        .i_cmd      (arith_cmd),
        .i_div_num  (div_num),
        .i_div_den  (div_den),
        .o_prod     (prod),
        .o_quo      (quo),
        .o_div_busy (div_busy),
        .o_div_done (div_done)
    );

    mac_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (win_cmd),
        .i_prob  (r_prob),
        .o_total (win_total),
        .o_fill  (win_fill)
    );

    // operand selection for the shared unit
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        arith_cmd = '0;
        div_num   = '0;
        div_den   = '0;
        win_cmd   = '0;
        unique case (r_state)
            S_T_MUL: begin
                mul_a = MUL_A_W'(r_decay);
                mul_b = it_clamped;
            end
            S_T_DIV: begin
                arith_cmd.div_go  = 1'b1;
                arith_cmd.div_cnt = DIV_CNT_W'(56);
                div_num           = {prod[55:0], 8'd0};
                div_den           = DEN_W'(eff_len);
            end
            S_TAY_MUL: begin
                mul_a = r_term;
                mul_b = r_f;
            end
            S_TAY_DIV: begin
                arith_cmd.div_go  = 1'b1;
                arith_cmd.div_cnt = DIV_CNT_W'(32);
                div_num           = {prod[63:32], 32'd0};
                div_den           = DEN_W'(r_k);
            end
            S_REC_DIV: begin
                arith_cmd.div_go  = 1'b1;
                arith_cmd.div_cnt = DIV_CNT_W'(64);
                div_num           = '1;
                div_den           = r_sum;
            end
            S_EXP_NEG: begin
                mul_a = r_y;
                mul_b = EXP_NEG_ONE_Q32;
            end
            S_EXP_DONE: begin
                mul_a = r_y;
                mul_b = r_start_temp;
            end
            S_T_ROUND: begin
                win_cmd.clear = (r_mode == MODE_CLEAR);
            end
            S_STEP_EVAL: begin
                arith_cmd.div_go  = is_worse && (r_temp != '0);
                arith_cmd.div_cnt = DIV_CNT_W'(48);
                div_num           = {mag, 32'd0};
                div_den           = DEN_W'(r_temp);
            end
            S_WIN_RD: begin
                win_cmd.rd = 1'b1;
            end
            S_WIN_WR: begin
                win_cmd.wr = 1'b1;
            end
            S_MEAN_GO: begin
                arith_cmd.div_go  = (win_fill != '0);
                arith_cmd.div_cnt = DIV_CNT_W'(TW);
                div_num           = {win_total, {(DIV_W-TW){1'b0}}};
                div_den           = DEN_W'(win_fill);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_maximize   <= 1'b1;
            r_start_temp <= START_TEMP_RST;
            r_decay      <= '0;
            r_run_length <= RUN_LENGTH_RST;
            r_count      <= '0;
            r_score      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAXIMIZE:   r_maximize   <= i_cfg_data[0];
                    CFG_START_TEMP: r_start_temp <= i_cfg_data;
                    CFG_DECAY:      r_decay      <= i_cfg_data[23:0];
                    CFG_RUN_LENGTH: r_run_length <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode     <= i_in.mode;
                        r_delta    <= i_in.score_delta;
                        r_rnd      <= i_in.random_fraction;
                        r_acc      <= 1'b0;
                        r_worse    <= 1'b0;
                        r_prob     <= '0;
                        r_ret_prob <= 1'b0;
                        if (i_in.mode == MODE_RESTART) begin
                            r_score <= i_in.initial_score;
                            r_count <= '0;
                        end
                        r_state <= S_T_MUL;
                    end
                end
                S_T_MUL: r_state <= S_T_DIV;
                S_T_DIV: r_state <= S_T_WAIT;
                S_T_WAIT: begin
                    if (div_done) begin
                        r_x     <= quo;
                        r_state <= S_EXP_START;
                    end
                end
                S_EXP_START: begin
                    r_n <= r_x[20:16];
                    r_f <= {r_x[15:0], 16'd0};
                    if (r_x[63:21] != '0) begin
                        r_y     <= '0;
                        r_state <= S_EXP_DONE;
                    end else if (r_x[15:0] == '0) begin
                        r_y     <= {1'b1, 32'd0};
                        r_state <= S_EXP_NEG;
                    end else begin
                        r_sum   <= {2'b01, 32'd0};
                        r_term  <= {1'b1, 32'd0};
                        r_k     <= 4'd1;
                        r_state <= S_TAY_MUL;
                    end
                end
                S_TAY_MUL: r_state <= S_TAY_DIV;
                S_TAY_DIV: r_state <= S_TAY_WAIT;
                S_TAY_WAIT: begin
                    if (div_done) begin
                        r_term <= {1'b0, quo[31:0]};
                        r_sum  <= r_sum + 34'(quo[31:0]);
                        if (r_k == TAYLOR_TERMS) begin
                            r_state <= S_REC_DIV;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_TAY_MUL;
                        end
                    end
                end
                S_REC_DIV: r_state <= S_REC_WAIT;
                S_REC_WAIT: begin
                    if (div_done) begin
                        r_y     <= quo[32:0];
                        r_state <= S_EXP_NEG;
                    end
                end
                // integer part: multiply by e^-1 once per unit, rounding half up
                S_EXP_NEG: r_state <= (r_n == '0) ? S_EXP_DONE : S_EXP_ACC;
                S_EXP_ACC: begin
                    r_y     <= prod_rnd[64:32];
                    r_n     <= r_n - 1'b1;
                    r_state <= S_EXP_NEG;
                end
                S_EXP_DONE: begin
                    if (r_ret_prob) begin
                        r_prob  <= (p_rnd[33:16] > 18'd65535) ? 16'hFFFF : p_rnd[31:16];
                        r_state <= S_WIN_RD;
                    end else begin
                        r_state <= S_T_ROUND;
                    end
                end
                S_T_ROUND: begin
                    r_temp  <= prod_rnd[63:32];
                    r_state <= (r_mode == MODE_STEP) ? S_STEP_EVAL : S_MEAN_GO;
                end
                S_STEP_EVAL: begin
                    if (!is_worse) begin
                        r_acc   <= 1'b1;
                        r_state <= S_SCORE;
                    end else begin
                        r_worse <= 1'b1;
                        // zero temperature: probability stays zero
                        r_state <= (r_temp == '0) ? S_WIN_RD : S_P_WAIT;
                    end
                end
                S_P_WAIT: begin
                    if (div_done) begin
                        r_x        <= quo;
                        r_ret_prob <= 1'b1;
                        r_state    <= S_EXP_START;
                    end
                end
                S_WIN_RD: r_state <= S_WIN_WR;
                S_WIN_WR: begin
                    r_acc   <= r_rnd < r_prob;
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    if (r_acc) begin
                        if (score_sum[48] != score_sum[47]) begin
                            r_score <= score_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                        end else begin
                            r_score <= score_sum[47:0];
                        end
                    end
                    r_count <= (r_count < eff_len) ? r_count + 1'b1 : eff_len;
                    r_state <= S_MEAN_GO;
                end
                S_MEAN_GO: begin
                    if (win_fill == '0) begin
                        r_mean  <= MEAN_EMPTY;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MEAN_WAIT;
                    end
                end
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean  <= quo[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready                = (r_state == S_IDLE);
    assign o_out.valid               = (r_state == S_OUT);
    assign o_out.accepted            = r_acc;
    assign o_out.worse_move          = r_worse;
    assign o_out.accept_probability  = r_prob;
    assign o_out.window_mean         = r_mean;
    assign o_out.current_temperature = r_temp;
    assign o_out.running_score       = r_score;
    assign o_out.run_done            = (r_count >= eff_len);

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input taken while a result is pending");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !div_busy)
        else $error("divider still running outside an item");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_fill <= FW'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    a_accept_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.worse_move && o_out.accepted) |->
            (r_rnd < o_out.accept_probability))
        else $error("worse move accepted above its probability");
endmodule

FILE: tb/sv/tb_metropolis_accept_with_cooling.sv
// self-checking testbench of the metropolis acceptance block with cooling schedule
// depends on mac_pkg, mac_in_if, mac_out_if and metropolis_accept_with_cooling
`timescale 1ns / 1ps
module tb_metropolis_accept_with_cooling;
    import mac_pkg::*;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] score_delta;
        logic [15:0]        random_fraction;
        logic signed [47:0] initial_score;
    } t_move;

    typedef struct packed {
        logic               accepted;
        logic               worse_move;
        logic [15:0]        accept_probability;
        logic [15:0]        window_mean;
        logic [31:0]        current_temperature;
        logic signed [47:0] running_score;
        logic               run_done;
    } t_decision;

    localparam int WDEPTH    = WINDOW_DEPTH_DEF;
    localparam int IDLE_LIMIT = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mac_in_if  in_ch();
    mac_out_if out_ch();

    metropolis_accept_with_cooling u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    logic        cfg_maximize;
    logic [31:0] cfg_start_temp;
    logic [23:0] cfg_decay;
    logic [31:0] cfg_run_length;
    logic [31:0] iter_count;
    logic signed [47:0] score_acc;
    logic [15:0] prob_window [WDEPTH];
    int unsigned win_pos, win_fill, win_total;

    t_move     pending_moves[$];
    t_decision expected_decisions[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        drive_en = 1'b0;

    function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
        logic [63:0] n, f, y, sum, term;
        logic [127:0] wide;
        n = x >> 16;
        f = (x & 64'hFFFF) << 16;
        if (n >= 32) return 64'd0;
        if (f == 0) begin
            y = 64'd1 << 32;
        end else begin
            sum = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int k = 1; k <= 14; k++) begin
                term = ((term * f) >> 32) / k;
                sum += term;
            end
            y = 64'hFFFF_FFFF_FFFF_FFFF / sum;
        end
        for (int i = 0; i < n; i++) begin
            wide = {64'd0, y} * EXP_NEG_ONE_Q32 + (128'd1 << 31);
            y = wide[95:32];
        end
        return y;
    endfunction

    function automatic logic [31:0] eff_length();
        return (cfg_run_length != 0) ? cfg_run_length : 32'd1;
    endfunction

    function automatic logic [31:0] schedule_temperature();
        logic [63:0] len, it, x, y;
        logic [127:0] wide;
        len = eff_length();
        it = (iter_count < len) ? iter_count : len;
        x = ({40'd0, cfg_decay} * it) / len;
        y = exp_neg_q32(x);
        wide = {96'd0, cfg_start_temp} * y + (128'd1 << 31);
        return wide[63:32];
    endfunction

    function automatic logic [15:0] window_mean_now();
        if (win_fill == 0) return MEAN_EMPTY;
        return 16'(win_total / win_fill);
    endfunction

    task automatic record_probability(input int unsigned p);
        int unsigned nxt, old;
        nxt = (win_pos >= WDEPTH - 1) ? 0 : win_pos + 1;
        if (win_fill >= WDEPTH) begin
            old = prob_window[nxt];
            win_total = (win_total >= old) ? win_total - old : 0;
            win_fill = WDEPTH;
        end else begin
            win_fill++;
        end
        win_pos = nxt;
        prob_window[nxt] = 16'(p);
        win_total += p;
    endtask

    task automatic predict_decision(input t_move mv);
        t_decision d;
        logic [31:0] temp, len;
        logic signed [63:0] delta, s;
        logic [63:0] mag, x, p;
        bit is_worse;
        d = '0;
        temp = schedule_temperature();
        if (mv.mode == MODE_STEP) begin
            delta = mv.score_delta;
            is_worse = cfg_maximize ? (delta < 0) : (delta > 0);
            len = eff_length();
            if (!is_worse) begin
                d.accepted = 1'b1;
            end else begin
                mag = (delta < 0) ? -delta : delta;
                d.worse_move = 1'b1;
                if (temp != 0) begin
                    x = (mag << 16) / temp;
                    p = (exp_neg_q32(x) + 64'd32768) >> 16;
                    d.accept_probability = (p > 65535) ? 16'hFFFF : p[15:0];
                end
                record_probability(d.accept_probability);
                d.accepted = mv.random_fraction < d.accept_probability;
            end
            if (d.accepted) begin
                s = score_acc + delta;
                if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
                if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
                score_acc = s[47:0];
            end
            iter_count = (iter_count < len) ? iter_count + 1 : len;
        end else if (mv.mode == MODE_CLEAR) begin
            win_total = 0;
            win_fill = 0;
            win_pos = 0;
        end else if (mv.mode == MODE_RESTART) begin
            score_acc = mv.initial_score;
            iter_count = 0;
            temp = schedule_temperature();
        end
        d.window_mean = window_mean_now();
        d.current_temperature = temp;
        d.running_score = score_acc;
        d.run_done = iter_count >= eff_length();
        expected_decisions.push_back(d);
    endtask

    // driver: bursts and gaps on the sending side
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_decision(pending_moves.pop_front());
                idle_cycles <= 0;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (drive_en && pending_moves.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.mode <= pending_moves[0].mode;
                in_ch.score_delta <= pending_moves[0].score_delta;
                in_ch.random_fraction <= pending_moves[0].random_fraction;
                in_ch.initial_score <= pending_moves[0].initial_score;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_decision got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                idle_cycles <= 0;
                got = {out_ch.accepted, out_ch.worse_move, out_ch.accept_probability,
                       out_ch.window_mean, out_ch.current_temperature,
                       out_ch.running_score, out_ch.run_done};
                if (expected_decisions.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got !== want) begin
                        error_count++;
                        $display("%0t: mismatch expected acc=%0b worse=%0b p=%0d mean=%0d T=%0d score=%0d done=%0b",
                                 $time, want.accepted, want.worse_move, want.accept_probability,
                                 want.window_mean, want.current_temperature,
                                 want.running_score, want.run_done);
                        $display("%0t: mismatch actual   acc=%0b worse=%0b p=%0d mean=%0d T=%0d score=%0d done=%0b",
                                 $time, got.accepted, got.worse_move, got.accept_probability,
                                 got.window_mean, got.current_temperature,
                                 got.running_score, got.run_done);
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 97;
            out_ch.ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAXIMIZE:   cfg_maximize = val[0];
            CFG_START_TEMP: cfg_start_temp = val;
            CFG_DECAY:      cfg_decay = val[23:0];
            default:        cfg_run_length = val;
        endcase
    endtask

    task automatic add_move(input logic [1:0] m, input logic [31:0] dl,
                            input logic [15:0] rf, input logic [47:0] is);
        t_move mv;
        mv.mode = m;
        mv.score_delta = dl;
        mv.random_fraction = rf;
        mv.initial_score = is;
        pending_moves.push_back(mv);
    endtask

    task automatic add_random(input int count);
        logic [31:0] dl;
        logic [1:0] m;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       dl = $urandom;
                1:       dl = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
                2, 3:    dl = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                default: dl = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            endcase
            case ($urandom_range(0, 39))
                0:       m = MODE_CLEAR;
                1:       m = MODE_RESTART;
                2:       m = MODE_UNUSED;
                default: m = MODE_STEP;
            endcase
            add_move(m, dl, 16'($urandom), 48'({$urandom, $urandom}));
        end
    endtask

    task automatic drain();
        drive_en = 1'b1;
        wait (pending_moves.size() == 0 && expected_decisions.size() == 0 && !in_ch.valid);
        drive_en = 1'b0;
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        cfg_maximize = 1'b1;
        cfg_start_temp = START_TEMP_RST;
        cfg_decay = '0;
        cfg_run_length = RUN_LENGTH_RST;
        iter_count = 0;
        score_acc = 0;
        win_pos = 0;
        win_fill = 0;
        win_total = 0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_STEP;
        in_ch.score_delta = '0;
        in_ch.random_fraction = '0;
        in_ch.initial_score = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, extremes, clear and restart, unused mode
        add_move(MODE_STEP, 32'sh0001_0000, 16'h0000, '0);
        add_move(MODE_STEP, -32'sh0000_8000, 16'h0000, '0);
        add_move(MODE_STEP, -32'sh0000_8000, 16'hFFFF, '0);
        add_move(MODE_STEP, 32'h8000_0000, 16'h0000, '0);
        add_move(MODE_STEP, 32'h7FFF_FFFF, 16'hFFFF, '0);
        add_move(MODE_STEP, 32'sd0, 16'hFFFF, '0);
        add_move(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        add_move(MODE_RESTART, '0, '0, 48'h7FFF_FFFF_FFFF);
        add_move(MODE_STEP, 32'h7FFF_FFFF, 16'd0, '0);
        add_move(MODE_RESTART, '0, '0, 48'h8000_0000_0000);
        add_move(MODE_STEP, 32'h8000_0000, 16'd0, '0);
        add_move(MODE_UNUSED, 32'h1234_5678, 16'h5555, 48'h0AAA_AAAA_AAAA);
        drain();

        // minimize, zero temperature, zero run length
        write_reg(CFG_MAXIMIZE, 32'd0);
        write_reg(CFG_START_TEMP, 32'd0);
        write_reg(CFG_RUN_LENGTH, 32'd0);
        write_reg(CFG_DECAY, 32'hFF_FFFF);
        add_move(MODE_STEP, 32'sd5, 16'd0, '0);
        add_move(MODE_STEP, -32'sd5, 16'd0, '0);
        add_move(MODE_STEP, 32'sd1, 16'd0, '0);
        drain();

        // short run with full decay, then a lowered run length
        write_reg(CFG_MAXIMIZE, 32'd1);
        write_reg(CFG_START_TEMP, 32'hFFFF_FFFF);
        write_reg(CFG_RUN_LENGTH, 32'd10);
        add_random(40);
        drain();
        write_reg(CFG_RUN_LENGTH, 32'd3);
        add_random(6);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_MAXIMIZE, $urandom_range(0, 1));
            write_reg(CFG_START_TEMP, ph == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 22));
            write_reg(CFG_DECAY, ph == 1 ? 32'hFF_FFFF : $urandom_range(0, 1 << 19));
            write_reg(CFG_RUN_LENGTH, ph == 2 ? 32'hFFFF_FFFF : $urandom_range(1, 200));
            add_random(95);
            drain();
        end

        if (error_count == 0 && expected_decisions.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
